[hw/rtl/lzwd_pkg.sv]
// lzwd_pkg: shared constants, parser phase type and command struct for the
// LZ window depacker. No dependencies.
package lzwd_pkg;

	// History window size and derived widths
	localparam int WINDOW_DEPTH = 4096;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

	// Match code layout: 11 distance bits, 4 length bits
	localparam int DIST_BITS = 11;
	localparam int LEN_BITS  = 4;
	localparam int DIST_W    = DIST_BITS + 1;   // holds 4..2051
	localparam int LEN_W     = LEN_BITS + 1;    // holds 2..17
	localparam int DIST_BIAS = 4;
	localparam int LEN_BIAS  = 2;

	// Control byte: top bit selects a literal run
	localparam int CTRL_LIT_BIT = 7;
	localparam int RUN_W        = 7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COUNT,
		PH_CTRL,
		PH_LIT,
		PH_MATCH,
		PH_DONE
	} phase_t;

	// Parser to copy engine command, valid for one cycle
	typedef struct packed {
		logic              go;          // command present
		logic              restart;     // new stream: clear window pointers
		logic              lit;         // 1: literal byte, 0: match
		logic [7:0]        data;        // literal byte
		logic [DIST_W-1:0] distance;    // match distance
		logic [LEN_W-1:0]  len;         // match length
		logic              last_block;  // this command closes the final block
	} cmd_t;

endpackage

[hw/rtl/lzwd_stream_if.sv]
// lzwd_stream_if: valid/ready channel interfaces for compressed input and
// decompressed output transactions. No dependencies.
interface lzwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_start;

	modport source (output valid, in_byte, stream_start, input ready);
	modport sink   (input valid, in_byte, stream_start, output ready);
endinterface

interface lzwd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       stream_end;
	logic       bad_offset;

	modport source (output valid, out_byte, last_of_run, stream_end, bad_offset,
		input ready);
	modport sink   (input valid, out_byte, last_of_run, stream_end, bad_offset,
		output ready);
endinterface

[hw/rtl/lzwd_ram.sv]
// lzwd_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/lzwd_parser.sv]
// lzwd_parser: stream header and control byte parser; turns accepted input
// transactions into literal / match commands. Depends on lzwd_pkg, lzwd_in_if.
module lzwd_parser (
	input  logic          clk,
	input  logic          arst_n,
	lzwd_in_if.sink       comp,
	input  logic          cmd_ready,
	output lzwd_pkg::cmd_t cmd
);
	import lzwd_pkg::*;

	phase_t           phase_q, phase_nx;
	logic [1:0]       idx_q, idx_nx;
	logic [31:0]      blocks_q, blocks_nx;
	logic [RUN_W-1:0] lit_left_q, lit_left_nx;
	logic [RUN_W-1:0] match_high_q, match_high_nx;

	logic             accept;
	phase_t           cur_phase;
	logic [1:0]       cur_idx;
	logic [31:0]      cur_blocks;
	logic [31:0]      blocks_dec;
	logic [14:0]      code;

	assign comp.ready = cmd_ready;
	assign accept     = comp.valid && comp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= '0;
			blocks_q     <= '0;
			lit_left_q   <= '0;
			match_high_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_nx;
			idx_q        <= idx_nx;
			blocks_q     <= blocks_nx;
			lit_left_q   <= lit_left_nx;
			match_high_q <= match_high_nx;
		end
	end

	always_comb begin
		// stream_start restarts the parser before the byte is looked at
		cur_phase  = comp.stream_start ? PH_COUNT : phase_q;
		cur_idx    = comp.stream_start ? 2'd0 : idx_q;
		cur_blocks = comp.stream_start ? 32'd0 : blocks_q;
		blocks_dec = cur_blocks - 32'd1;
		code       = {match_high_q, comp.in_byte};

		phase_nx      = cur_phase;
		idx_nx        = cur_idx;
		blocks_nx     = cur_blocks;
		lit_left_nx   = comp.stream_start ? '0 : lit_left_q;
		match_high_nx = comp.stream_start ? '0 : match_high_q;

		cmd            = '0;
		cmd.restart    = accept && comp.stream_start;
		cmd.data       = comp.in_byte;
		cmd.distance   = DIST_W'({1'b0, code[DIST_BITS-1:0]} + DIST_W'(DIST_BIAS));
		cmd.len        = LEN_W'({1'b0, code[DIST_BITS +: LEN_BITS]} + LEN_W'(LEN_BIAS));
		cmd.last_block = (blocks_dec == 32'd0);

		unique case (cur_phase)
			PH_COUNT: begin
				unique case (cur_idx)
					2'd0: blocks_nx[7:0]   = comp.in_byte;
					2'd1: blocks_nx[15:8]  = comp.in_byte;
					2'd2: blocks_nx[23:16] = comp.in_byte;
					default: blocks_nx[31:24] = comp.in_byte;
				endcase
				if (cur_idx == 2'd3) begin
					idx_nx   = 2'd0;
					phase_nx = (blocks_nx == 32'd0) ? PH_DONE : PH_CTRL;
				end else begin
					idx_nx = cur_idx + 2'd1;
				end
			end
			PH_CTRL: begin
				if (comp.in_byte[CTRL_LIT_BIT]) begin
					lit_left_nx = comp.in_byte[RUN_W-1:0];
					if (comp.in_byte[RUN_W-1:0] == '0) begin
						// empty run closes the block silently
						blocks_nx = blocks_dec;
						phase_nx  = (blocks_dec == 32'd0) ? PH_DONE : PH_CTRL;
					end else begin
						phase_nx = PH_LIT;
					end
				end else begin
					match_high_nx = comp.in_byte[RUN_W-1:0];
					phase_nx      = PH_MATCH;
				end
			end
			PH_LIT: begin
				cmd.go      = accept;
				cmd.lit     = 1'b1;
				lit_left_nx = lit_left_q - RUN_W'(1);
				if (lit_left_nx == '0) begin
					blocks_nx = blocks_dec;
					phase_nx  = (blocks_dec == 32'd0) ? PH_DONE : PH_CTRL;
				end else begin
					cmd.last_block = 1'b0;
				end
			end
			PH_MATCH: begin
				cmd.go    = accept;
				blocks_nx = blocks_dec;
				phase_nx  = (blocks_dec == 32'd0) ? PH_DONE : PH_CTRL;
			end
			default: begin
				// idle before a stream or trailing bytes after the last block
			end
		endcase
	end

endmodule

[hw/rtl/lz_window_depacker.sv]
// lz_window_depacker: top level; copy engine over a single window read port,
// output register. Depends on lzwd_pkg, lzwd_stream_if, lzwd_ram, lzwd_parser.
//
// Usage:
//   comp  : compressed byte transactions (in_byte, stream_start). A byte with
//           stream_start opens a stream: 4-byte little-endian block count,
//           then per block a control byte (literal run or 2-byte match).
//   plain : decompressed byte transactions with last_of_run, stream_end and
//           bad_offset flags. Both channels use valid/ready.
// Flow:
//   - header, control and match-high bytes: accepted with no output.
//   - literal data byte: one output.
//   - match low byte: accepted, then 2..17 window reads, one per output byte,
//     through the single RAM read port; comp.ready stays low until the last
//     read of the match is issued.
// Output path: each issued read or literal goes through the issue register,
//   then the output register.
// Stall: when plain.ready is low a full output register holds, a full issue
//   stage freezes and comp.ready drops; nothing is lost.
// Reset: parser idle until stream_start; window pointers cleared. The window
//   RAM itself is not cleared: bytes before the stream's first output are
//   never used, those copies come out as zero with bad_offset.
module lz_window_depacker (
	input  logic       clk,
	input  logic       arst_n,
	lzwd_in_if.sink    comp,
	lzwd_out_if.source plain
);
	import lzwd_pkg::*;

	cmd_t cmd;
	logic cmd_ready;

	lzwd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.comp      (comp),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Window pointers, advanced when a byte is issued
	logic [ADDR_W-1:0]  wp_q, wp_inc;
	logic [COUNT_W-1:0] prod_q, prod_inc;

	// Active match
	logic [LEN_W-1:0]   match_left_q;
	logic [DIST_W-1:0]  dist_q;
	logic               end_q;

	// Issue stage: byte waiting for window data / write-back
	logic               valid_s1;
	logic [ADDR_W-1:0]  waddr_s1;
	logic               lit_s1;
	logic [7:0]         data_s1;
	logic               bad_s1;
	logic               last_s1;
	logic               end_s1;

	logic               adv;
	logic               slot_free;
	logic               issue_match;
	logic               issue_lit;
	logic [ADDR_W:0]    src_wrap;
	logic [ADDR_W-1:0]  src_addr;
	logic               src_bad;
	logic [7:0]         ram_rdata;
	logic [7:0]         value;

	// Issue stage moves into the output register when it is free or draining
	assign adv       = valid_s1 && (!plain.valid || plain.ready);
	assign slot_free = !valid_s1 || adv;
	assign cmd_ready = (match_left_q == '0) && slot_free;

	assign issue_match = (match_left_q != '0) && slot_free;
	assign issue_lit   = cmd.go && cmd.lit;

	assign wp_inc   = (wp_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
	assign prod_inc = (prod_q == COUNT_W'(WINDOW_DEPTH)) ? prod_q : prod_q + COUNT_W'(1);

	// Source = write position minus distance, modulo the window
	assign src_wrap = {1'b0, wp_q} + (ADDR_W + 1)'(WINDOW_DEPTH) - (ADDR_W + 1)'(dist_q);
	assign src_addr = (wp_q >= ADDR_W'(dist_q)) ? wp_q - ADDR_W'(dist_q)
		: src_wrap[ADDR_W-1:0];
	assign src_bad  = COUNT_W'(dist_q) > prod_q;

	// distance >= 4 keeps every read clear of the write still in flight
	assign value = bad_s1 ? 8'd0 : (lit_s1 ? data_s1 : ram_rdata);

	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (adv),
		.waddr (waddr_s1),
		.wdata (value),
		.re    (issue_match),
		.raddr (src_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			prod_q       <= '0;
			match_left_q <= '0;
			valid_s1     <= 1'b0;
			plain.valid  <= 1'b0;
		end else begin
			if (cmd.restart) begin
				wp_q   <= '0;
				prod_q <= '0;
			end else if (issue_match || issue_lit) begin
				wp_q   <= wp_inc;
				prod_q <= prod_inc;
			end

			if (cmd.go && !cmd.lit) begin
				match_left_q <= cmd.len;
			end else if (issue_match) begin
				match_left_q <= match_left_q - LEN_W'(1);
			end

			if (issue_match || issue_lit) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				plain.valid <= 1'b1;
			end else if (plain.ready) begin
				plain.valid <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.go && !cmd.lit) begin
			dist_q <= cmd.distance;
			end_q  <= cmd.last_block;
		end

		if (issue_lit) begin
			waddr_s1 <= wp_q;
			lit_s1   <= 1'b1;
			data_s1  <= cmd.data;
			bad_s1   <= 1'b0;
			last_s1  <= 1'b1;
			end_s1   <= cmd.last_block;
		end else if (issue_match) begin
			waddr_s1 <= wp_q;
			lit_s1   <= 1'b0;
			data_s1  <= 8'd0;
			bad_s1   <= src_bad;
			last_s1  <= (match_left_q == LEN_W'(1));
			end_s1   <= end_q && (match_left_q == LEN_W'(1));
		end

		if (adv) begin
			plain.out_byte    <= value;
			plain.last_of_run <= last_s1;
			plain.stream_end  <= end_s1;
			plain.bad_offset  <= bad_s1;
		end
	end

endmodule

[tb/sv/lzwd_checker.sv]
`timescale 1ns / 100ps
// lzwd_checker: passive scoreboard for lz_window_depacker. It predicts the decompressed
// stream from the accepted compressed transactions and compares every output transaction.
// Depends on lzwd_pkg and lzwd_stream_if.
module lzwd_checker (
	input  logic clk,
	input  logic arst_n,
	lzwd_in_if   comp,
	lzwd_out_if  plain,
	output int   fail_count,
	output int   pending
);
	import lzwd_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       stream_end;
		logic       bad_offset;
	} plain_beat_t;

	plain_beat_t exp_bytes[$];
	int          errs;

	// Shadow of the parser and window
	phase_t             ph;
	logic [1:0]         cnt_idx;
	logic [31:0]        blocks_left;
	logic [RUN_W-1:0]   lit_left;
	logic [7:0]         mhigh;
	logic [7:0]         hist [WINDOW_DEPTH];
	logic [ADDR_W-1:0]  wpos;
	logic [COUNT_W-1:0] produced;

	task automatic keep_byte(input logic [7:0] v);
		hist[wpos] = v;
		wpos = wpos + 1'b1;
		if (int'(produced) < WINDOW_DEPTH)
			produced = produced + 1'b1;
	endtask

	task automatic close_block(output logic fin);
		blocks_left = blocks_left - 1'b1;
		fin = (blocks_left == 32'd0);
		ph = fin ? PH_DONE : PH_CTRL;
	endtask

	// Expected output bytes caused by one compressed byte
	task automatic depack_byte(input logic [7:0] b, input logic s);
		logic [14:0] code;
		int          distance;
		int          len;
		int          src;
		logic        fin;
		logic [7:0]  v;
		logic        bad;
		plain_beat_t beat;
		fin = 1'b0;
		if (s) begin
			ph = PH_COUNT;
			cnt_idx = '0;
			blocks_left = '0;
			lit_left = '0;
			mhigh = '0;
			wpos = '0;
			produced = '0;
		end
		case (ph)
			PH_COUNT: begin
				blocks_left = blocks_left | ({24'd0, b} << (8 * cnt_idx));
				if (cnt_idx == 2'd3) begin
					cnt_idx = '0;
					ph = (blocks_left == 32'd0) ? PH_DONE : PH_CTRL;
				end else begin
					cnt_idx = cnt_idx + 1'b1;
				end
			end
			PH_CTRL: begin
				if (b[CTRL_LIT_BIT]) begin
					lit_left = b[RUN_W-1:0];
					if (lit_left == '0)
						close_block(fin);
					else
						ph = PH_LIT;
				end else begin
					mhigh = b;
					ph = PH_MATCH;
				end
			end
			PH_LIT: begin
				keep_byte(b);
				lit_left = lit_left - 1'b1;
				if (lit_left == '0)
					close_block(fin);
				beat.out_byte = b;
				beat.last_of_run = 1'b1;
				beat.stream_end = fin;
				beat.bad_offset = 1'b0;
				exp_bytes.push_back(beat);
			end
			PH_MATCH: begin
				code = {mhigh[6:0], b};
				distance = int'(code[DIST_BITS-1:0]) + DIST_BIAS;
				len = int'(code[14:DIST_BITS]) + LEN_BIAS;
				close_block(fin);
				for (int j = 0; j < len; j++) begin
					bad = (distance > int'(produced));
					if (bad) begin
						v = 8'd0;
					end else begin
						src = (int'(wpos) + WINDOW_DEPTH - distance) % WINDOW_DEPTH;
						v = hist[src];
					end
					keep_byte(v);
					beat.out_byte = v;
					beat.last_of_run = (j == len - 1);
					beat.stream_end = fin && (j == len - 1);
					beat.bad_offset = bad;
					exp_bytes.push_back(beat);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		plain_beat_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			cnt_idx = '0;
			blocks_left = '0;
			lit_left = '0;
			mhigh = '0;
			wpos = '0;
			produced = '0;
			exp_bytes.delete();
			errs = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (comp.valid && comp.ready)
				depack_byte(comp.in_byte, comp.stream_start);
			if (plain.valid && plain.ready) begin
				if (exp_bytes.size() == 0) begin
					$error("unexpected output transaction: out_byte %02h", plain.out_byte);
					errs++;
				end else begin
					want = exp_bytes.pop_front();
					if (plain.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte,
							plain.out_byte);
						errs++;
					end
					if (plain.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b", want.last_of_run,
							plain.last_of_run);
						errs++;
					end
					if (plain.stream_end !== want.stream_end) begin
						$error("stream_end: expected %0b, got %0b", want.stream_end,
							plain.stream_end);
						errs++;
					end
					if (plain.bad_offset !== want.bad_offset) begin
						$error("bad_offset: expected %0b, got %0b", want.bad_offset,
							plain.bad_offset);
						errs++;
					end
				end
			end
			pending <= exp_bytes.size();
			fail_count <= errs;
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for lz_window_depacker; directed streams, then random ones.
// Depends on lzwd_pkg, lzwd_stream_if, lz_window_depacker and lzwd_checker.
module tb_top;
	import lzwd_pkg::*;

	localparam int RAND_ITEMS  = 120;   // compressed bytes in the random part
	localparam int GAP_MAX     = 6;     // longest sender gap, cycles
	localparam int IDLE_LIMIT  = 1000;  // cycles with no transaction on either side
	localparam int TAIL_CYCLES = 12;    // settle time after the drain; generous margin

	// Receiver stall patterns
	localparam int RX_OPEN     = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_THROTTLE = 2;

	logic clk;
	logic arst_n;

	lzwd_in_if  comp_if ();
	lzwd_out_if plain_if ();

	int chk_fails;
	int chk_pending;

	lz_window_depacker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.comp   (comp_if),
		.plain  (plain_if)
	);

	lzwd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp       (comp_if),
		.plain      (plain_if),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender state: burst bookkeeping plus a rough count of bytes produced in the
	// current stream, so random matches can be aimed inside the live window.
	int burst_left = 0;
	int live_items = 0;
	int made = 0;
	int long_done = 0;

	// One compressed transaction. Between bursts valid drops for a random gap.
	// Returns at the edge where the transaction was accepted, valid still high.
	task automatic send_byte(input logic [7:0] b, input logic s);
		if (burst_left == 0) begin
			comp_if.valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		comp_if.valid <= 1'b1;
		comp_if.in_byte <= b;
		comp_if.stream_start <= s;
		@(posedge clk);
		while (!comp_if.ready) @(posedge clk);
	endtask

	// 4-byte little-endian block count, first byte opens the stream
	task automatic send_count(input logic [31:0] n);
		send_byte(n[7:0], 1'b1);
		send_byte(n[15:8], 1'b0);
		send_byte(n[23:16], 1'b0);
		send_byte(n[31:24], 1'b0);
		live_items += 4;
		made = 0;
	endtask

	// Literal run of n random data bytes; n = 0 is the empty run
	task automatic send_literal(input int n);
		send_byte({1'b1, 7'(n)}, 1'b0);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		live_items += n + 1;
		made += n;
	endtask

	// Match block: distance 4..2051, len 2..17
	task automatic send_match(input int distance, input int len);
		logic [14:0] code;
		code = {4'(len - LEN_BIAS), 11'(distance - DIST_BIAS)};
		send_byte({1'b0, code[14:8]}, 1'b0);
		send_byte(code[7:0], 1'b0);
		live_items += 2;
		made += len;
	endtask

	// Stop sending and wait for every predicted output. The checker's count is
	// registered, so the wait begins only once that count has been updated.
	task automatic drain();
		comp_if.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
	endtask

	// Receiver: pattern switches between always ready, random stalls and a
	// fixed 3-of-8 throttle, each for a random stretch.
	int rx_mode;
	int rx_left;
	int rx_tick;

	initial begin
		plain_if.ready <= 1'b0;
		rx_mode = RX_OPEN;
		rx_left = 0;
		rx_tick = 0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = $urandom_range(RX_OPEN, RX_THROTTLE);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:   plain_if.ready <= 1'b1;
				RX_RANDOM: plain_if.ready <= ($urandom_range(0, 3) != 0);
				default:   plain_if.ready <= ((rx_tick % 8) < 3);
			endcase
		end
	end

	// Watchdog: a correct run never goes this long without a transaction
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((comp_if.valid && comp_if.ready) || (plain_if.valid && plain_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int roll;
		int nblk;
		int pick;
		int distance;
		int len;
		int k;

		comp_if.valid <= 1'b0;
		comp_if.in_byte <= 8'd0;
		comp_if.stream_start <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// a byte before any stream is ignored
		send_byte(8'hA7, 1'b0);
		// stream aborted in the middle of its block count
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		// five blocks: literal with extreme data, shortest match that starts before
		// the stream's first byte and then hits history, empty run, one literal,
		// longest match at the farthest distance (all bad offsets, ends the stream)
		send_count(32'd5);
		send_byte(8'h83, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_match(4, 2);
		send_literal(0);
		send_literal(1);
		send_match(2051, 17);
		// trailing byte after the last block is ignored
		send_byte(8'h3C, 1'b0);
		// zero block count ends the stream at once
		send_count(32'd0);
		// final block is an empty run: nothing carries stream_end
		send_count(32'd1);
		send_literal(0);

		// hold off until every expected byte has come out
		drain();

		// ---- random part ----
		live_items = 0;
		while (live_items < RAND_ITEMS) begin
			roll = $urandom_range(0, 9);
			if (roll < 8) begin
				// well-formed stream, random content
				nblk = $urandom_range(1, 6);
				send_count(32'(nblk));
				for (int i = 0; i < nblk; i++) begin
					pick = $urandom_range(0, 19);
					if (!long_done && (pick == 1 || live_items > RAND_ITEMS / 2)) begin
						send_literal(127);
						long_done = 1;
					end else if (pick == 0) begin
						send_literal(0);
					end else if (pick < 10) begin
						send_literal($urandom_range(1, 8));
					end else begin
						len = $urandom_range(2, 17);
						if (pick < 17 && made >= 4)
							distance = $urandom_range(4, (made > 2051) ? 2051 : made);
						else
							distance = $urandom_range(4, 2051);
						send_match(distance, len);
					end
				end
				// occasional ignored trailing bytes
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(1, 3);
					for (int i = 0; i < k; i++)
						send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end else begin
				// noise: random count, random body, cut off by the next stream
				send_byte(8'($urandom_range(0, 255)), 1'b1);
				for (int i = 0; i < 3; i++)
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				k = $urandom_range(0, 8);
				for (int i = 0; i < k; i++)
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				live_items += 4 + k;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (chk_fails == 0 && chk_pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
